// ----- rtl/wgacc_pkg.sv -----
// Shared types and constants for the Winograd F(2,3) tile accumulator.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package wgacc_pkg;

  localparam int unsigned TILE         = 4;            // tile edge
  localparam int unsigned GRID         = TILE * TILE;  // elements per tile
  localparam int unsigned DATA_W       = 8;            // data byte
  localparam int unsigned WGT_W        = 12;           // transformed weight
  localparam int unsigned T_W          = DATA_W + 1;   // after row pass
  localparam int unsigned V_W          = DATA_W + 2;   // after column pass
  localparam int unsigned PROD_W       = V_W + WGT_W;  // lane product
  localparam int unsigned ROW_W        = TILE * DATA_W;
  localparam int unsigned WROW_W       = TILE * WGT_W;
  localparam int unsigned OUT_W        = 32;
  localparam int unsigned ACC_BITS_DEF = 32;

  typedef logic [V_W-1:0]    v_t;
  typedef logic [WGT_W-1:0]  w_t;
  typedef logic [ROW_W-1:0]  drow_t;
  typedef logic [WROW_W-1:0] wrow_t;
  typedef logic [OUT_W-1:0]  out_t;

  // Lane strobes from the stage control in the top level, shared by all lanes.
  typedef struct packed {
    logic prod_load;  // capture v*w from the transform register
    logic consume;    // fold the held product into the accumulator
    logic last;       // held product closes the channel sum
  } lane_ctrl_t;

  // Strobes for the two output transform stages.
  typedef struct packed {
    logic sa_load;    // column pass register
    logic y_load;     // output register
  } merge_ctrl_t;

endpackage

// ----- rtl/wgacc_if.sv -----
// Valid/ready channel interfaces for the tile accumulator.
// Depends on wgacc_pkg, which the input interface imports.
`timescale 1ns / 1ps

interface wgacc_in_if;
  import wgacc_pkg::*;
  logic          valid;
  logic          ready;
  logic [31:0]   data_row0;
  logic [31:0]   data_row1;
  logic [31:0]   data_row2;
  logic [31:0]   data_row3;
  logic [47:0]   weight_row0;
  logic [47:0]   weight_row1;
  logic [47:0]   weight_row2;
  logic [47:0]   weight_row3;
  logic          last_channel;

  modport source (
    output valid, data_row0, data_row1, data_row2, data_row3,
           weight_row0, weight_row1, weight_row2, weight_row3, last_channel,
    input  ready
  );
  modport sink (
    input  valid, data_row0, data_row1, data_row2, data_row3,
           weight_row0, weight_row1, weight_row2, weight_row3, last_channel,
    output ready
  );
endinterface

interface wgacc_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] y_top_left;
  logic signed [31:0] y_top_right;
  logic signed [31:0] y_bottom_left;
  logic signed [31:0] y_bottom_right;

  modport source (
    output valid, y_top_left, y_top_right, y_bottom_left, y_bottom_right,
    input  ready
  );
  modport sink (
    input  valid, y_top_left, y_top_right, y_bottom_left, y_bottom_right,
    output ready
  );
endinterface

// ----- rtl/winograd_f23_tile_accumulator.sv -----
// Winograd F(2,3) tile accumulator: input transform, 16 MAC lanes, output
// transform. Depends on wgacc_pkg, wgacc_if, wgacc_in_xform, wgacc_lane,
// wgacc_merge.
// Throughput: one channel tile per cycle on 16 parallel lanes, unless
// output back-pressure holds a last-channel tile, which passes S1 to S5.
// Reset: asynchronous, clears all stage valids and the accumulators.
`timescale 1ns / 1ps

module winograd_f23_tile_accumulator import wgacc_pkg::*; #(
  parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  wgacc_in_if.sink    in_i,
  wgacc_out_if.source out_o
);

  // Pipeline:
  //   S1  input transform register (v, w)
  //   S2  lane product register
  //   S3  accumulate; a last item latches the full sum into res and clears
  //   S4  output transform column pass
  //   S5  output register
  // Every stage takes a new entry when it is empty or its own entry moves.
  // Items that are not last retire at S3, so only one result travels on.

  logic s1_valid_q, s1_last_q;
  logic s2_valid_q, s2_last_q;
  logic res_valid_q, sa_valid_q, y_valid_q;

  logic in_xfer, s1_ready, s2_ready, s2_consume;
  logic res_ready, sa_ready, y_ready;

  drow_t drow [TILE];
  wrow_t wrow [TILE];
  v_t    v    [GRID];
  w_t    w    [GRID];
  logic [ACC_BITS-1:0] res [GRID];
  out_t  y    [4];

  lane_ctrl_t  lane_ctrl;
  merge_ctrl_t merge_ctrl;

  // ready chain, back to front
  assign y_ready    = !y_valid_q || out_o.ready;
  assign sa_ready   = !sa_valid_q || y_ready;
  assign res_ready  = !res_valid_q || sa_ready;
  // a non-last product only updates the accumulator and never waits
  assign s2_consume = s2_valid_q && (!s2_last_q || res_ready);
  assign s2_ready   = !s2_valid_q || s2_consume;
  assign s1_ready   = !s1_valid_q || s2_ready;

  assign in_i.ready = s1_ready;
  assign in_xfer    = in_i.valid && s1_ready;

  assign lane_ctrl.prod_load = s1_valid_q && s2_ready;
  assign lane_ctrl.consume   = s2_consume;
  assign lane_ctrl.last      = s2_last_q;

  assign merge_ctrl.sa_load  = res_valid_q && sa_ready;
  assign merge_ctrl.y_load   = sa_valid_q && y_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_last_q   <= 1'b0;
      s2_valid_q  <= 1'b0;
      s2_last_q   <= 1'b0;
      res_valid_q <= 1'b0;
      sa_valid_q  <= 1'b0;
      y_valid_q   <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid_q <= in_xfer;
        s1_last_q  <= in_i.last_channel;
      end
      if (s2_ready) begin
        s2_valid_q <= s1_valid_q;
        s2_last_q  <= s1_last_q;
      end
      if (res_ready) begin
        res_valid_q <= s2_consume && s2_last_q;
      end
      if (sa_ready) begin
        sa_valid_q <= res_valid_q;
      end
      if (y_ready) begin
        y_valid_q <= sa_valid_q;
      end
    end
  end

  assign drow[0] = in_i.data_row0;
  assign drow[1] = in_i.data_row1;
  assign drow[2] = in_i.data_row2;
  assign drow[3] = in_i.data_row3;
  assign wrow[0] = in_i.weight_row0;
  assign wrow[1] = in_i.weight_row1;
  assign wrow[2] = in_i.weight_row2;
  assign wrow[3] = in_i.weight_row3;

  wgacc_in_xform u_xform (
    .clk_i  (clk_i),
    .load_i (in_xfer),
    .data_i (drow),
    .wgt_i  (wrow),
    .v_o    (v),
    .w_o    (w)
  );

  for (genvar k = 0; k < GRID; k++) begin : g_lane
    wgacc_lane #(
      .ACC_BITS (ACC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (lane_ctrl),
      .v_i    (v[k]),
      .w_i    (w[k]),
      .res_o  (res[k])
    );
  end

  wgacc_merge #(
    .ACC_BITS (ACC_BITS)
  ) u_merge (
    .clk_i  (clk_i),
    .ctrl_i (merge_ctrl),
    .res_i  (res),
    .y_o    (y)
  );

  assign out_o.valid          = y_valid_q;
  assign out_o.y_top_left     = y[0];
  assign out_o.y_top_right    = y[1];
  assign out_o.y_bottom_left  = y[2];
  assign out_o.y_bottom_right = y[3];

  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> s1_valid_q)
    else $error("accepted transfer did not reach transform stage");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s2_ready |=> s1_valid_q && $stable(s1_last_q))
    else $error("stalled transform stage lost its entry");

  a_last_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_consume && s2_last_q |=> res_valid_q)
    else $error("last channel did not produce a lane sum");

  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !sa_ready |=> res_valid_q)
    else $error("stalled lane sum dropped");

endmodule

// ----- rtl/wgacc_in_xform.sv -----
// Input transform B^T d B on one 4x4 byte tile, registered with the weights.
// Depends on wgacc_pkg.
`timescale 1ns / 1ps

module wgacc_in_xform import wgacc_pkg::*; (
  input  logic  clk_i,
  input  logic  load_i,
  input  drow_t data_i [TILE],
  input  wrow_t wgt_i  [TILE],
  output v_t    v_o    [GRID],
  output w_t    w_o    [GRID]
);

  logic [DATA_W-1:0] d [TILE][TILE];
  logic [T_W-1:0]    t [TILE][TILE];
  logic [T_W-1:0]    dx [TILE][TILE];
  v_t                tx [TILE][TILE];
  v_t                v_d [GRID];
  w_t                w_d [GRID];
  v_t                v_q [GRID];
  w_t                w_q [GRID];

  // Modular arithmetic on sign-extended operands: the values never overflow
  // the widths, so the low bits carry the exact two's-complement result.
  always_comb begin
    for (int i = 0; i < TILE; i++) begin
      for (int j = 0; j < TILE; j++) begin
        d[i][j]  = data_i[i][j*DATA_W +: DATA_W];
        dx[i][j] = {d[i][j][DATA_W-1], d[i][j]};
        w_d[i*TILE+j] = wgt_i[i][j*WGT_W +: WGT_W];
      end
    end
    // rows: t = B^T d
    for (int j = 0; j < TILE; j++) begin
      t[0][j] = dx[0][j] - dx[2][j];
      t[1][j] = dx[1][j] + dx[2][j];
      t[2][j] = dx[2][j] - dx[1][j];
      t[3][j] = dx[1][j] - dx[3][j];
    end
    for (int i = 0; i < TILE; i++) begin
      for (int j = 0; j < TILE; j++) begin
        tx[i][j] = {t[i][j][T_W-1], t[i][j]};
      end
    end
    // columns: v = t B
    for (int i = 0; i < TILE; i++) begin
      v_d[i*TILE+0] = tx[i][0] - tx[i][2];
      v_d[i*TILE+1] = tx[i][1] + tx[i][2];
      v_d[i*TILE+2] = tx[i][2] - tx[i][1];
      v_d[i*TILE+3] = tx[i][1] - tx[i][3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      v_q <= v_d;
      w_q <= w_d;
    end
  end

  assign v_o = v_q;
  assign w_o = w_q;

endmodule

// ----- rtl/wgacc_lane.sv -----
// One accumulator lane: registered product v*w and a wrapping accumulator.
// Depends on wgacc_pkg.
`timescale 1ns / 1ps

module wgacc_lane import wgacc_pkg::*; #(
  parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lane_ctrl_t          ctrl_i,
  input  v_t                  v_i,
  input  w_t                  w_i,
  output logic [ACC_BITS-1:0] res_o
);

  logic [PROD_W-1:0]   v_x, w_x, prod_d, prod_q;
  logic [ACC_BITS-1:0] sum, acc_d, acc_q, res_q;

  assign v_x    = {{(PROD_W-V_W){v_i[V_W-1]}}, v_i};
  assign w_x    = {{(PROD_W-WGT_W){w_i[WGT_W-1]}}, w_i};
  assign prod_d = v_x * w_x;
  assign sum    = acc_q + {{(ACC_BITS-PROD_W){prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.consume) begin
      acc_d = ctrl_i.last ? '0 : sum;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_load) begin
      prod_q <= prod_d;
    end
    if (ctrl_i.consume && ctrl_i.last) begin
      res_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  assign res_o = res_q;

  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_i.consume && ctrl_i.last |=> acc_q == '0)
    else $error("lane accumulator not cleared after last channel");

  a_hold_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ctrl_i.consume |=> acc_q == $past(acc_q))
    else $error("lane accumulator changed without a consume");

endmodule

// ----- rtl/wgacc_merge.sv -----
// Output transform A^T M A over the sixteen lane sums, two register stages.
// Depends on wgacc_pkg.
`timescale 1ns / 1ps

module wgacc_merge import wgacc_pkg::*; #(
  parameter int unsigned ACC_BITS = ACC_BITS_DEF
) (
  input  logic                clk_i,
  input  merge_ctrl_t         ctrl_i,
  input  logic [ACC_BITS-1:0] res_i [GRID],
  output out_t                y_o   [4]
);

  out_t m [GRID];
  out_t sa_d [2][TILE];
  out_t sa_q [2][TILE];
  out_t y_d [4];
  out_t y_q [4];

  // Lane sums read as signed ACC_BITS values, truncated or sign-extended to 32 bits.
  for (genvar k = 0; k < GRID; k++) begin : g_m
    if (ACC_BITS >= OUT_W) begin : g_trunc
      assign m[k] = res_i[k][OUT_W-1:0];
    end else begin : g_sext
      assign m[k] = {{(OUT_W-ACC_BITS){res_i[k][ACC_BITS-1]}}, res_i[k]};
    end
  end

  always_comb begin
    for (int j = 0; j < TILE; j++) begin
      sa_d[0][j] = m[j] + m[TILE+j] + m[2*TILE+j];
      sa_d[1][j] = m[TILE+j] - m[2*TILE+j] - m[3*TILE+j];
    end
    for (int i = 0; i < 2; i++) begin
      y_d[2*i]   = sa_q[i][0] + sa_q[i][1] + sa_q[i][2];
      y_d[2*i+1] = sa_q[i][1] - sa_q[i][2] - sa_q[i][3];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sa_load) begin
      sa_q <= sa_d;
    end
    if (ctrl_i.y_load) begin
      y_q <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

// ----- test/tb.sv -----
// Self-checking bench for winograd_f23_tile_accumulator: drives channel tiles,
// predicts the 2x2 outputs in a scoreboard class. Depends on wgacc_pkg, wgacc_if
// and the RTL of the block.
`timescale 1ns / 1ps

module tb;
  import wgacc_pkg::*;

  localparam int unsigned STUCK_LIMIT = 500;  // cycles with no transfer at all
  localparam int unsigned DRAIN       = 20;   // tail after the last result
  localparam int unsigned WRAP_RUN    = 300;  // long channel, large lane sums
  localparam int unsigned RAND_ITEMS  = 570;
  localparam int unsigned CALM_TAIL   = 150;  // final items sent without idling

  // One channel tile as it crosses the input port.
  typedef struct {
    drow_t data [TILE];
    wrow_t wgt  [TILE];
    logic  last;
  } tile_t;

  // One 2x2 output block: top-left, top-right, bottom-left, bottom-right.
  typedef struct {
    out_t px [4];
  } pixels_t;

  // Tracks the sixteen channel sums and the output blocks they must produce.
  class pixel_sum_tracker;
    logic [31:0] lane_sum [GRID];
    pixels_t     awaited [$];
    int          mismatches;

    function new();
      foreach (lane_sum[k]) lane_sum[k] = '0;
      mismatches = 0;
    endfunction

    task report_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // Input transform B^T d B, lane products into the sums; on the closing
    // channel the output transform A^T M A gives the expected block.
    function void absorb_tile(tile_t t);
      logic [31:0] d [4][4];
      logic [31:0] w [4][4];
      logic [31:0] r [4][4];
      logic [31:0] v [4][4];
      logic [31:0] s [2][4];
      pixels_t     y;
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          d[i][j] = {{24{t.data[i][8*j+7]}}, t.data[i][8*j +: 8]};
          w[i][j] = {{20{t.wgt[i][12*j+11]}}, t.wgt[i][12*j +: 12]};
        end
      end
      for (int j = 0; j < 4; j++) begin
        r[0][j] = d[0][j] - d[2][j];
        r[1][j] = d[1][j] + d[2][j];
        r[2][j] = d[2][j] - d[1][j];
        r[3][j] = d[1][j] - d[3][j];
      end
      for (int i = 0; i < 4; i++) begin
        v[i][0] = r[i][0] - r[i][2];
        v[i][1] = r[i][1] + r[i][2];
        v[i][2] = r[i][2] - r[i][1];
        v[i][3] = r[i][1] - r[i][3];
        for (int j = 0; j < 4; j++) begin
          lane_sum[4*i+j] = lane_sum[4*i+j] + v[i][j] * w[i][j];
        end
      end
      if (!t.last) return;
      for (int j = 0; j < 4; j++) begin
        s[0][j] = lane_sum[j] + lane_sum[4+j] + lane_sum[8+j];
        s[1][j] = lane_sum[4+j] - lane_sum[8+j] - lane_sum[12+j];
      end
      for (int i = 0; i < 2; i++) begin
        y.px[2*i]   = s[i][0] + s[i][1] + s[i][2];
        y.px[2*i+1] = s[i][1] - s[i][2] - s[i][3];
      end
      awaited.push_back(y);
      foreach (lane_sum[k]) lane_sum[k] = '0;
    endfunction

    task check_pixels(pixels_t got);
      pixels_t exp_px;
      string   names [4];
      names = '{"y_top_left", "y_top_right", "y_bottom_left", "y_bottom_right"};
      if (awaited.size() == 0) begin
        report_mismatch("output block with no channel sum closed");
        return;
      end
      exp_px = awaited.pop_front();
      for (int k = 0; k < 4; k++) begin
        if (got.px[k] !== exp_px.px[k]) begin
          report_mismatch($sformatf("%s got %0d expected %0d", names[k],
                                    $signed(got.px[k]), $signed(exp_px.px[k])));
        end
      end
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   no_idle;     // set for the tail of the run: both sides stream
  int   ready_hold;  // remaining cycles of the current ready/stall burst
  int   stuck;

  pixel_sum_tracker sums;

  wgacc_in_if  in_bus ();
  wgacc_out_if out_bus ();

  winograd_f23_tile_accumulator i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #5 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Monitors: sample both channels at the rising edge; inputs were driven on
  // the falling edge, so the values seen here are settled.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : in_monitor
    tile_t seen;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      seen.data = '{in_bus.data_row0, in_bus.data_row1, in_bus.data_row2, in_bus.data_row3};
      seen.wgt  = '{in_bus.weight_row0, in_bus.weight_row1,
                    in_bus.weight_row2, in_bus.weight_row3};
      seen.last = in_bus.last_channel;
      sums.absorb_tile(seen);
    end
  end

  always @(posedge clk_i) begin : out_monitor
    pixels_t got;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      got.px = '{out_bus.y_top_left, out_bus.y_top_right,
                 out_bus.y_bottom_left, out_bus.y_bottom_right};
      sums.check_pixels(got);
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      stuck <= 0;
    end else begin
      stuck <= stuck + 1;
    end
    if (stuck >= STUCK_LIMIT) begin
      $display("winograd_f23_tile_accumulator test failed");
      $finish;
    end
  end

  // Output ready: random ready or stall bursts; after no_idle is set, high once the burst ends.
  always @(negedge clk_i) begin
    if (ready_hold > 0) begin
      ready_hold--;
    end else if (no_idle) begin
      out_bus.ready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_bus.ready <= 1'b0;
      ready_hold = $urandom_range(0, 7);
    end else begin
      out_bus.ready <= 1'b1;
      ready_hold = $urandom_range(0, 7);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Biased toward the corners of the signed byte range.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h80;
      1: return 8'h7F;
      2: return 8'hFF;
      3: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [11:0] pick_weight();
    case ($urandom_range(0, 7))
      0: return 12'h800;
      1: return 12'h7FF;
      2: return 12'hFFF;
      3: return 12'h000;
      default: return 12'($urandom);
    endcase
  endfunction

  function automatic tile_t random_tile(logic last);
    tile_t t;
    for (int i = 0; i < TILE; i++) begin
      for (int j = 0; j < TILE; j++) begin
        t.data[i][8*j +: 8]  = pick_byte();
        t.wgt[i][12*j +: 12] = pick_weight();
      end
    end
    t.last = last;
    return t;
  endfunction

  // Every element the same byte, every weight the same value.
  function automatic tile_t flat_tile(logic [7:0] b, logic [11:0] wv, logic last);
    tile_t t;
    for (int i = 0; i < TILE; i++) begin
      t.data[i] = {4{b}};
      t.wgt[i]  = {4{wv}};
    end
    t.last = last;
    return t;
  endfunction

  // Present one tile, maybe after an idle gap, and hold it until the transfer.
  // valid stays high afterwards so back-to-back tiles stream without a bubble.
  task automatic send_tile(tile_t t);
    int gap;
    gap = (!no_idle && $urandom_range(0, 7) == 0) ? $urandom_range(1, 8) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_bus.data_row0    <= t.data[0];
    in_bus.data_row1    <= t.data[1];
    in_bus.data_row2    <= t.data[2];
    in_bus.data_row3    <= t.data[3];
    in_bus.weight_row0  <= t.wgt[0];
    in_bus.weight_row1  <= t.wgt[1];
    in_bus.weight_row2  <= t.wgt[2];
    in_bus.weight_row3  <= t.wgt[3];
    in_bus.last_channel <= t.last;
    in_bus.valid        <= 1'b1;
    do @(posedge clk_i); while (!in_bus.ready);
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    tile_t t;
    int    left;
    int    len;

    sums                = new();
    clk_i               = 1'b0;
    rst_ni              = 1'b0;
    no_idle             = 1'b0;
    ready_hold          = 0;
    stuck               = 0;
    in_bus.valid        = 1'b0;
    in_bus.data_row0    = '0;
    in_bus.data_row1    = '0;
    in_bus.data_row2    = '0;
    in_bus.data_row3    = '0;
    in_bus.weight_row0  = '0;
    in_bus.weight_row1  = '0;
    in_bus.weight_row2  = '0;
    in_bus.weight_row3  = '0;
    in_bus.last_channel = 1'b0;
    out_bus.ready       = 1'b0;

    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // Corners: zero tile, max/min/minus-one sums over a 3-channel group,
    // then opposite-sign extremes on single channels.
    send_tile(flat_tile(8'h00, 12'h000, 1'b1));
    send_tile(flat_tile(8'h7F, 12'h7FF, 1'b0));
    send_tile(flat_tile(8'h80, 12'h800, 1'b0));
    send_tile(flat_tile(8'hFF, 12'hFFF, 1'b1));
    send_tile(flat_tile(8'h80, 12'h7FF, 1'b1));
    send_tile(flat_tile(8'h7F, 12'h800, 1'b1));

    // Checkerboard of the byte extremes against alternating weight extremes.
    t = flat_tile(8'h00, 12'h000, 1'b1);
    t.data = '{32'h807F807F, 32'h7F807F80, 32'h807F807F, 32'h7F807F80};
    t.wgt  = '{48'h7FF8007FF800, 48'h8007FF8007FF, 48'h7FF8007FF800, 48'h8007FF8007FF};
    send_tile(t);

    // One data element at a time: catches swapped rows, columns or lanes.
    for (int k = 0; k < GRID; k++) begin
      t = random_tile(1'b1);
      foreach (t.data[i]) t.data[i] = '0;
      t.data[k/4][8*(k%4) +: 8] = (k % 2 == 0) ? 8'h7F : 8'h80;
      send_tile(t);
    end

    // Long channel of near-maximum lane products: nine lanes build large
    // sums of opposite sign that must cancel in the output transform.
    t.data = '{32'h81817F7F, 32'h81817F7F, 32'h7F7F8181, 32'h7F7F8181};
    t.wgt  = '{48'h800800800800, 48'h800800800800, 48'h800800800800, 48'h800800800800};
    for (int n = 0; n < WRAP_RUN; n++) begin
      t.last = (n == WRAP_RUN - 1);
      send_tile(t);
    end

    // Random channel groups, mostly short, some long; the tail streams.
    left = RAND_ITEMS;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 48) : $urandom_range(1, 8);
      if (len > left) len = left;
      for (int k = 0; k < len; k++) begin
        if (left <= CALM_TAIL) no_idle = 1'b1;
        send_tile(random_tile(k == len - 1));
        left--;
      end
    end

    @(negedge clk_i);
    in_bus.valid <= 1'b0;

    // The watchdog bounds this wait if a block never shows up.
    while (sums.awaited.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    if (sums.mismatches == 0 && sums.awaited.size() == 0) begin
      $display("winograd_f23_tile_accumulator test passed");
    end else begin
      $display("winograd_f23_tile_accumulator test failed");
    end
    $finish;
  end

endmodule
